>>> design/hims_pkg.sv
// Shared types and constants of the hybrid insertion merge sorter.
package hims_pkg;

	localparam int unsigned DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		data_t    key;
	} cell_ctrl_t;

endpackage

>>> design/hims_cell.sv
// One cell of the sorting chain: holds one value, inserts or shifts toward the head.
module hims_cell (
	input  logic                clk,
	input  hims_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  hims_pkg::data_t     left_val,
	input  logic                left_gt,
	input  hims_pkg::data_t     right_val,
	output hims_pkg::data_t     val,
	output logic                gt
);
	import hims_pkg::*;

	data_t val_q;

	// An empty cell acts as plus infinity, so a new key always lands in front of it.
	// Equal values do not move, which keeps ties in arrival order.
	assign gt  = !occupied || (val_q > ctrl.key);
	assign val = val_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_INSERT: begin
				if (gt) begin
					val_q <= left_gt ? left_val : ctrl.key;
				end
			end
			CELL_SHIFT: begin
				val_q <= right_val;
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

endmodule

>>> design/hybrid_insertion_merge_sorter.sv
// Top level of the hybrid insertion merge sorter: a systolic insertion chain with burst drain.
// Latency: an input transaction is absorbed at the edge that accepts it; the first sorted result is
// presented in the cycle after the transaction that carries tlast.
// Throughput: one input per cycle while a run fills; the drain then pops one stored value
// (at most MAX_ITEMS) per taken result, as the chain shifts one cell toward the head.
// Reset clears the fill count, the overflow flag and the state; cell contents are not reset.
module hybrid_insertion_merge_sorter #(
	parameter int unsigned MAX_ITEMS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tlast,   // last_in
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sorted_value
	output logic        m_tlast,   // last_out
	output logic [0:0]  m_tuser    // [0] overflowed
);
	import hims_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);
	localparam logic [CW-1:0] ONE  = CW'(1);

	// Filling collects a run in the chain; draining pops the head once per result.
	typedef enum logic [1:0] {
		ST_FILL  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic            ovf_q;

	logic            in_acc;
	logic            out_acc;
	logic            full;
	cell_ctrl_t      ctrl;

	data_t           cell_val [MAX_ITEMS];
	logic            cell_gt  [MAX_ITEMS];

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign full    = (count_q == FULL);

	assign s_tready = (state_q == ST_FILL);
	assign m_tvalid = (state_q == ST_DRAIN);
	assign m_tdata  = cell_val[0];
	assign m_tlast  = (count_q == ONE);
	assign m_tuser  = ovf_q;

	// A value is inserted only while there is room; the whole chain shifts when the
	// head result is taken.
	always_comb begin
		ctrl.key = s_tdata;
		ctrl.op  = CELL_HOLD;
		if (in_acc && !full) begin
			ctrl.op = CELL_INSERT;
		end else if (out_acc) begin
			ctrl.op = CELL_SHIFT;
		end
	end

	// Each cell looks at its left neighbor when inserting and its right one when shifting.
	// The cells below count_q are occupied, as the chain always fills from the head.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		data_t lval;
		logic  lgt;
		data_t rval;

		if (i == 0) begin : g_head
			assign lval = '0;
			assign lgt  = 1'b0;
		end else begin : g_body
			assign lval = cell_val[i-1];
			assign lgt  = cell_gt[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign rval = '0;
		end else begin : g_inner
			assign rval = cell_val[i+1];
		end

		hims_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (count_q > CW'(i)),
			.left_val  (lval),
			.left_gt   (lgt),
			.right_val (rval),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	// Control: count values in, flag drops, then count results out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + ONE;
						end
						if (s_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (out_acc) begin
						count_q <= count_q - ONE;
						if (count_q == ONE) begin
							state_q <= ST_FILL;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	// A drain always has at least one result to give.
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (count_q != '0))
		else $error("drain with an empty chain");

	// The fill count never passes the chain length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("fill count beyond capacity");

	// After the final result is taken, the next run starts empty and without overflow.
	a_run_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> (s_tready && count_q == '0 && !ovf_q))
		else $error("run state not cleared after final result");

	// A transaction with tlast always leads into the drain.
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tlast) |=> m_tvalid)
		else $error("no drain after final input");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench of the hybrid insertion merge sorter: directed runs, random runs, stalls.
module tb_top;

	import hims_pkg::*;

	// Capacity of the sorter under test; the predictor drops values beyond it.
	localparam int unsigned CAPACITY = 16;
	// Cycles without any transaction on either side before the run is declared hung.
	localparam int unsigned HANG_LIMIT = 2000;
	// Length of the long receiver hold-off used to fill the sorter and stall its input.
	localparam int unsigned HOLD_CYCLES = 150;

	// One expected sorted output transaction.
	typedef struct {
		data_t value;
		logic  last;
		logic  ovf;
	} sorted_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic        s_tlast;   // last_in
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] sorted_value
	logic        m_tlast;   // last_out
	logic [0:0]  m_tuser;   // [0] overflowed

	// Predictor state: the current run kept in ascending order, and its overflow flag.
	data_t        sorted_run[$];
	bit           run_overflowed;
	// Sorted results that the block still owes, oldest first.
	sorted_item_t expected_sorted[$];

	int unsigned  error_count;
	int unsigned  tx_idle_pct;
	int unsigned  rx_idle_pct;
	int unsigned  hold_requests;

	hybrid_insertion_merge_sorter #(
		.MAX_ITEMS(CAPACITY)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Prints one line for a mismatch and counts it; the run carries on to its normal end.
	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Predicts the effect of one accepted input transaction. A value joins the run after
	// every stored value that is not greater than it, which keeps ties in arrival order.
	// Once the run holds CAPACITY values, further values are dropped and flagged. The
	// transaction that carries tlast releases the whole run as expected results.
	function automatic void absorb_value(input data_t value, input logic last);
		int           pos;
		sorted_item_t item;
		pos = sorted_run.size();
		if (sorted_run.size() < CAPACITY) begin
			while (pos > 0 && sorted_run[pos-1] > value) begin
				pos--;
			end
			sorted_run.insert(pos, value);
		end else begin
			run_overflowed = 1'b1;
		end
		if (last) begin
			foreach (sorted_run[k]) begin
				item.value = sorted_run[k];
				item.last  = (k == sorted_run.size() - 1);
				item.ovf   = run_overflowed;
				expected_sorted.push_back(item);
			end
			sorted_run.delete();
			run_overflowed = 1'b0;
		end
	endfunction

	// Monitor: both handshakes are sampled at the rising edge, when the testbench-driven
	// inputs have been stable since the falling edge. Input is predicted before output is checked,
	// although the block never returns a result in the cycle of its own tlast.
	always @(posedge clk) begin
		sorted_item_t exp_item;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				absorb_value(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (expected_sorted.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing expected",
						$signed(m_tdata)));
				end else begin
					exp_item = expected_sorted.pop_front();
					if (m_tdata !== exp_item.value) begin
						report_mismatch($sformatf("sorted_value %0d, expected %0d",
							$signed(m_tdata), exp_item.value));
					end
					if (m_tlast !== exp_item.last) begin
						report_mismatch($sformatf("last_out %b, expected %b (value %0d)",
							m_tlast, exp_item.last, exp_item.value));
					end
					if (m_tuser[0] !== exp_item.ovf) begin
						report_mismatch($sformatf("overflowed %b, expected %b (value %0d)",
							m_tuser[0], exp_item.ovf, exp_item.value));
					end
				end
			end
		end
	end

	// Receiver: m_tready changes at the falling edge. Normally it idles at random at the
	// current rate; a hold-off request makes it refuse results until a count loaded from
	// HOLD_CYCLES runs out, while the sender keeps offering input.
	initial begin
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Watchdog: ends the run if no transaction happens on either side for too long.
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("ERROR: no transaction for %0d cycles", HANG_LIMIT);
		$display("hybrid_insertion_merge_sorter regression: fail");
		$finish;
	end

	// Offers one input transaction and returns at the rising edge that accepts it. The
	// sender may idle first; every change of the inputs happens at a falling edge.
	task automatic send_value(input data_t value, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Takes the input valid down after the final transaction of a test.
	task automatic release_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Draws one random value; the flavor chooses full-range, narrow (many ties) or extremes.
	function automatic data_t pick_value(input int unsigned flavor);
		data_t v;
		case (flavor)
			0: begin
				v = $urandom;
			end
			1: begin
				v = $signed($urandom_range(8)) - 4;
			end
			default: begin
				case ($urandom_range(4))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
		endcase
		return v;
	endfunction

	// Sends one run of random values with tlast on its final transaction.
	task automatic send_random_run(input int unsigned len);
		int unsigned flavor;
		flavor = ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 2);
		for (int unsigned i = 0; i < len; i++) begin
			send_value(pick_value(flavor), i == len - 1);
		end
	endtask

	// Directed runs: single-value runs at both signed extremes, a short run with the
	// extremes and a duplicate, and an over-long run whose final value is itself dropped.
	task automatic test_directed();
		data_t short_run[5];
		short_run = '{0, -1, 32'sh7fff_ffff, 32'sh8000_0000, -1};
		send_value(32'sh7fff_ffff, 1'b1);
		send_value(32'sh8000_0000, 1'b1);
		foreach (short_run[i]) begin
			send_value(short_run[i], i == 4);
		end
		// Seventeen values: the store fills with the first sixteen, which descend, the
		// seventeenth carries tlast and is dropped, and every result is flagged.
		for (int i = 0; i <= CAPACITY; i++) begin
			send_value(32'sh7fff_fff0 - (i * 32'sh1000_0001), i == CAPACITY);
		end
		release_input();
	endtask

	// Random runs, mostly within capacity with a share of full and overflowing runs.
	task automatic test_random_runs(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				len = $urandom_range(1, CAPACITY - 1);
			end else if (pick < 87) begin
				len = CAPACITY;
			end else begin
				len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
			end
			send_random_run(len);
			sent += len;
		end
		release_input();
	endtask

	// Output back-pressure: the receiver holds off for a long stretch while a full run
	// and a following run are offered, so the sorter fills up and stalls its input.
	task automatic test_output_stall();
		hold_requests++;
		send_random_run(CAPACITY);
		send_random_run(5);
		release_input();
	endtask

	// Waits until every expected result has arrived, then keeps sampling so that any
	// surplus result would still be seen. The watchdog bounds the wait.
	task automatic wait_for_drain();
		while (expected_sorted.size() != 0) begin
			@(posedge clk);
		end
		repeat (CAPACITY + 8) @(posedge clk);
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		error_count    = 0;
		tx_idle_pct    = 0;
		rx_idle_pct    = 0;
		hold_requests  = 0;
		run_overflowed = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 8;
		rx_idle_pct = 49;
		test_directed();
		test_random_runs(135);

		tx_idle_pct = 49;
		rx_idle_pct = 8;
		test_random_runs(135);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_runs(135);
		test_output_stall();

		wait_for_drain();
		if (expected_sorted.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_sorted.size()));
		end
		if (sorted_run.size() != 0) begin
			report_mismatch("run left open at the end of the stimulus");
		end
		if (error_count == 0) begin
			$display("hybrid_insertion_merge_sorter regression: pass");
		end else begin
			$display("hybrid_insertion_merge_sorter regression: fail");
		end
		$finish;
	end

endmodule
